FILE: src/rds_pkg.sv
// Shared types and constants for the reaction-diffusion stencil.
`timescale 1ns / 1ps

package rds_pkg;

	localparam int VAL_W         = 16;
	localparam int FRAC_BITS_DEF = 12;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [1:0] {
		REG_GAIN  = 2'd0,
		REG_RATE  = 2'd1,
		REG_LEVEL = 2'd2,
		REG_HOLD  = 2'd3
	} reg_index_t;

	localparam logic [VAL_W-1:0] GAIN_RST  = 16'd52;
	localparam logic [VAL_W-1:0] RATE_RST  = 16'd3277;
	localparam logic [VAL_W-1:0] LEVEL_RST = 16'd3277;
	localparam logic [VAL_W-1:0] HOLD_RST  = 16'd3277;

	localparam logic [VAL_W-1:0] SAT_MAX = 16'h7fff;
	localparam logic [VAL_W-1:0] SAT_MIN = 16'h8000;

	typedef struct packed {
		logic signed [VAL_W-1:0] left;
		logic signed [VAL_W-1:0] centre;
		logic signed [VAL_W-1:0] right;
		logic                    last;
	} job_t;

	typedef struct packed {
		logic        [VAL_W-1:0] gain;
		logic        [VAL_W-1:0] rate;
		logic signed [VAL_W-1:0] level;
		logic signed [VAL_W-1:0] hold;
	} cfg_t;

endpackage

FILE: src/rds_front.sv
// Front end: input window over the row and job generation.
`timescale 1ns / 1ps

module rds_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [rds_pkg::VAL_W-1:0] cell_value,
	input  logic                            last_cell,
	output logic                            push,
	output rds_pkg::job_t                   push_job,
	input  logic                            q_full
);

	logic                             have_q;
	logic signed [rds_pkg::VAL_W-1:0] left_q;
	logic signed [rds_pkg::VAL_W-1:0] centre_q;
	logic                             pend_valid_q;
	rds_pkg::job_t                    pend_job_q;
	logic                             accept;
	rds_pkg::job_t                    job_a;
	rds_pkg::job_t                    job_b;

	assign in_stall = pend_valid_q || q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		job_a.left   = left_q;
		job_a.centre = centre_q;
		job_a.right  = cell_value;
		job_a.last   = 1'b0;
		job_b.left   = have_q ? centre_q : '0;
		job_b.centre = cell_value;
		job_b.right  = '0;
		job_b.last   = 1'b1;
	end

	always_comb begin
		push     = 1'b0;
		push_job = job_a;
		if (pend_valid_q) begin
			push     = !q_full;
			push_job = pend_job_q;
		end else if (accept) begin
			push     = have_q || last_cell;
			push_job = have_q ? job_a : job_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q       <= 1'b0;
			left_q       <= '0;
			centre_q     <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_valid_q && !q_full) begin
				pend_valid_q <= 1'b0;
			end
			if (accept) begin
				pend_valid_q <= have_q && last_cell;
				if (last_cell) begin
					have_q   <= 1'b0;
					left_q   <= '0;
					centre_q <= '0;
				end else begin
					have_q   <= 1'b1;
					left_q   <= centre_q;
					centre_q <= cell_value;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_job_q <= job_b;
		end
	end

	ap_pend_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !accept)
		else $error("input accepted while a second job is pending");

endmodule

FILE: src/rds_queue.sv
// Short job queue between front end and arithmetic back end.
`timescale 1ns / 1ps

module rds_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rds_pkg::job_t push_job,
	output logic          full,
	output logic          head_valid,
	output rds_pkg::job_t head_job,
	input  logic          pop
);

	localparam int DEPTH = rds_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rds_pkg::job_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	ap_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into a full queue");

endmodule

FILE: src/rds_back.sv
// Back end: pipelined cell update with saturation and output register.
`timescale 1ns / 1ps

module rds_back #(
	parameter int FRAC_BITS = rds_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rds_pkg::cfg_t                    cfg,
	input  logic                             head_valid,
	input  rds_pkg::job_t                    head_job,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rds_pkg::VAL_W-1:0] new_value,
	output logic                             row_end
);

	localparam int VW     = rds_pkg::VAL_W;
	localparam int LAP_W  = VW + 2;
	localparam int SPAN_W = VW + 1;
	localparam int DP_W   = SPAN_W + LAP_W;
	localparam int RP_W   = VW + SPAN_W;
	localparam int PROD_W = RP_W - FRAC_BITS;
	localparam int RCP_W  = SPAN_W + PROD_W;
	localparam int DIFF_W = DP_W - VW;
	localparam int REAC_W = RCP_W - VW;
	localparam int SUM_W  = ((REAC_W > DIFF_W) ? REAC_W : DIFF_W) + 2;

	logic adv;

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     last_s1, last_s2, last_s3;
	logic                     hold_s1, hold_s2, hold_s3;
	logic signed [VW-1:0]     u_s1, u_s2, u_s3;
	logic signed [LAP_W-1:0]  lap_s1;
	logic signed [SPAN_W-1:0] span_s1;
	logic signed [DP_W-1:0]   dprod_s2;
	logic signed [RP_W-1:0]   rprod_s2;
	logic signed [DIFF_W-1:0] diff_s3;
	logic signed [RCP_W-1:0]  rcp_s3;

	logic                     out_valid_q;
	logic signed [VW-1:0]     new_value_q;
	logic                     row_end_q;

	logic signed [SPAN_W-1:0] gain_x;
	logic signed [SPAN_W-1:0] rate_x;
	logic signed [PROD_W-1:0] prod;
	logic signed [REAC_W-1:0] reac;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-VW:0]        sum_hi;
	logic signed [VW-1:0]     sat;

	assign adv    = !out_valid_q || !out_stall;
	assign pop    = head_valid && adv;
	assign gain_x = $signed({1'b0, cfg.gain});
	assign rate_x = $signed({1'b0, cfg.rate});
	assign prod   = $signed(rprod_s2[RP_W-1:FRAC_BITS]);
	assign reac   = $signed(rcp_s3[RCP_W-1:VW]);

	always_comb begin
		sum    = SUM_W'(u_s3) + SUM_W'(diff_s3) + SUM_W'(reac);
		sum_hi = sum[SUM_W-1:VW-1];
		if (sum_hi == '0 || sum_hi == '1) begin
			sat = sum[VW-1:0];
		end else begin
			sat = sum[SUM_W-1] ? rds_pkg::SAT_MIN : rds_pkg::SAT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1     <= head_job.centre;
			last_s1  <= head_job.last;
			hold_s1  <= (head_job.centre == cfg.hold);
			lap_s1   <= LAP_W'(head_job.left) + LAP_W'(head_job.right)
				- (LAP_W'(head_job.centre) <<< 1);
			span_s1  <= SPAN_W'(cfg.level) - SPAN_W'(head_job.centre);

			u_s2     <= u_s1;
			last_s2  <= last_s1;
			hold_s2  <= hold_s1;
			dprod_s2 <= gain_x * lap_s1;
			rprod_s2 <= u_s1 * span_s1;

			u_s3     <= u_s2;
			last_s3  <= last_s2;
			hold_s3  <= hold_s2;
			diff_s3  <= $signed(dprod_s2[DP_W-1:VW]);
			rcp_s3   <= rate_x * prod;

			new_value_q <= hold_s3 ? u_s3 : sat;
			row_end_q   <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign new_value = new_value_q;
	assign row_end   = row_end_q;

	ap_hold_pass: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && hold_s3 && adv |=> new_value_q == $past(u_s3))
		else $error("held cell not passed through");

	ap_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_s1)
		else $error("popped job lost before first stage");

endmodule

FILE: src/reaction_diffusion_stencil_1d.sv
// Top level of the one-dimensional reaction-diffusion stencil.
`timescale 1ns / 1ps
// Usage:
// Cells of a row stream in on in_valid/in_stall with cell_value and
// last_cell; a transaction completes when in_valid is high and in_stall low.
// Each cell yields its update one cell later, when its right neighbor is in;
// a last cell ending a row of two or more yields two, the second with row_end.
// Results leave on out_valid/out_stall as new_value and row_end.
// After the transaction that completes its window, a result passes the queue,
// the three arithmetic stages and the output register.
// Throughput: one cell per cycle while in_stall is low; a last cell that closes
// a row of two or more leaves its second job pending, which stalls input, since
// the front end pushes one job per cycle into the 4-entry queue.
// When the receiver stalls, the output register holds, the pipeline freezes,
// the queue fills and then in_stall rises.
// Reset clears the row window, the queue and the pipeline, and loads the
// default gain, rate, carrying level and hold level. Write registers over
// cfg_valid/cfg_ready (always ready) only while the block is idle.

module reaction_diffusion_stencil_1d #(
	parameter int FRAC_BITS = rds_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [rds_pkg::VAL_W-1:0] cell_value,
	input  logic                             last_cell,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rds_pkg::VAL_W-1:0] new_value,
	output logic                             row_end,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [rds_pkg::VAL_W-1:0]        cfg_data
);

	rds_pkg::cfg_t cfg_q;
	logic          push;
	rds_pkg::job_t push_job;
	logic          q_full;
	logic          head_valid;
	rds_pkg::job_t head_job;
	logic          pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain  <= rds_pkg::GAIN_RST;
			cfg_q.rate  <= rds_pkg::RATE_RST;
			cfg_q.level <= rds_pkg::LEVEL_RST;
			cfg_q.hold  <= rds_pkg::HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rds_pkg::reg_index_t'(cfg_index))
				rds_pkg::REG_GAIN:  cfg_q.gain  <= cfg_data;
				rds_pkg::REG_RATE:  cfg_q.rate  <= cfg_data;
				rds_pkg::REG_LEVEL: cfg_q.level <= cfg_data;
				rds_pkg::REG_HOLD:  cfg_q.hold  <= cfg_data;
				default:            cfg_q       <= cfg_q;
			endcase
		end
	end

	rds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_value (cell_value),
		.last_cell  (last_cell),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	rds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	rds_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.new_value  (new_value),
		.row_end    (row_end)
	);

endmodule

FILE: sim/rds_checker.sv
// Checker that predicts and compares the stencil's updated cell values.
`timescale 1ns / 1ps

module rds_checker
	import rds_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [VAL_W-1:0] cell_value,
	input  logic                    last_cell,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [VAL_W-1:0] new_value,
	input  logic                    row_end,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [VAL_W-1:0]        cfg_data,
	output int                      mismatches,
	output int                      outstanding
);

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    row_end;
	} cell_update_t;

	cell_update_t due_updates[$];

	logic        [VAL_W-1:0] gain_q;
	logic        [VAL_W-1:0] rate_q;
	logic signed [VAL_W-1:0] level_q;
	logic signed [VAL_W-1:0] hold_q;
	logic signed [VAL_W-1:0] left_q;
	logic signed [VAL_W-1:0] centre_q;
	logic        [1:0]       fill_q;

	function automatic logic signed [VAL_W-1:0] next_concentration(
		input logic signed [VAL_W-1:0] l,
		input logic signed [VAL_W-1:0] u,
		input logic signed [VAL_W-1:0] r
	);
		longint lap;
		longint diff;
		longint prod;
		longint reac;
		longint total;
		if (u == hold_q)
			return u;
		lap   = longint'(l) + longint'(r) - 2 * longint'(u);
		diff  = (longint'(gain_q) * lap) >>> 16;
		prod  = (longint'(u) * (longint'(level_q) - longint'(u))) >>> FRAC_BITS_DEF;
		reac  = (longint'(rate_q) * prod) >>> 16;
		total = longint'(u) + diff + reac;
		if (total > 32767)
			total = 32767;
		else if (total < -32768)
			total = -32768;
		return VAL_W'(total);
	endfunction

	function automatic void queue_update(input logic signed [VAL_W-1:0] v, input logic e);
		cell_update_t item;
		item.value   = v;
		item.row_end = e;
		due_updates = {due_updates, item};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_update_t want;
		if (!arst_n) begin
			gain_q      = GAIN_RST;
			rate_q      = RATE_RST;
			level_q     = LEVEL_RST;
			hold_q      = HOLD_RST;
			left_q      = '0;
			centre_q    = '0;
			fill_q      = '0;
			mismatches  = 0;
			outstanding = 0;
			due_updates.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN:  gain_q  = cfg_data;
					REG_RATE:  rate_q  = cfg_data;
					REG_LEVEL: level_q = cfg_data;
					REG_HOLD:  hold_q  = cfg_data;
					default:   ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (due_updates.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected transaction new_value=%0d row_end=%b",
							$realtime, new_value, row_end);
					mismatches++;
				end else begin
					want = due_updates.pop_front();
					if (new_value !== want.value) begin
						if (mismatches < 10)
							$display("%0t: new_value expected %0d got %0d",
								$realtime, want.value, new_value);
						mismatches++;
					end
					if (row_end !== want.row_end) begin
						if (mismatches < 10)
							$display("%0t: row_end expected %b got %b",
								$realtime, want.row_end, row_end);
						mismatches++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				if (fill_q == 0) begin
					left_q   = '0;
					centre_q = cell_value;
				end else begin
					queue_update(next_concentration(left_q, centre_q, cell_value), 1'b0);
					left_q   = centre_q;
					centre_q = cell_value;
				end
				if (fill_q < 2)
					fill_q = fill_q + 2'd1;
				if (last_cell) begin
					queue_update(next_concentration(left_q, centre_q, '0), 1'b1);
					left_q   = '0;
					centre_q = '0;
					fill_q   = '0;
				end
			end

			outstanding = due_updates.size();
		end
	end

endmodule

FILE: sim/tb_reaction_diffusion_stencil_1d.sv
// Stimulus and verdict for the reaction-diffusion stencil.
`timescale 1ns / 1ps

module tb_reaction_diffusion_stencil_1d;
	import rds_pkg::*;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic signed [VAL_W-1:0] cell_value = '0;
	logic                    last_cell  = 1'b0;
	logic                    out_stall  = 1'b0;
	logic                    cfg_valid  = 1'b0;
	logic [1:0]              cfg_index  = REG_GAIN;
	logic [VAL_W-1:0]        cfg_data   = '0;

	logic                    in_stall;
	logic                    out_valid;
	logic signed [VAL_W-1:0] new_value;
	logic                    row_end;
	logic                    cfg_ready;

	int mismatches;
	int outstanding;

	logic signed [VAL_W-1:0] cur_level = LEVEL_RST;
	logic signed [VAL_W-1:0] cur_hold  = HOLD_RST;
	bit                      row_burst = 1'b0;

	always #5 clk = ~clk;

	reaction_diffusion_stencil_1d dut (.*);

	rds_checker chk (.*);

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver side: random stall before each transaction, with stall-free runs
	initial begin
		int gap;
		int run;
		bit no_stall;
		run      = 0;
		no_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (run == 0) begin
				run      = $urandom_range(10, 60);
				no_stall = ($urandom_range(0, 3) == 0);
			end
			run--;
			gap = no_stall ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	task automatic send_cell(input logic signed [VAL_W-1:0] v, input logic last);
		int gap;
		gap = row_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		cell_value <= v;
		last_cell  <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_regs(
		input logic [VAL_W-1:0] gain,
		input logic [VAL_W-1:0] rate,
		input logic [VAL_W-1:0] level,
		input logic [VAL_W-1:0] hold
	);
		reg_index_t       order [4];
		logic [VAL_W-1:0] vals  [4];
		order = '{REG_GAIN, REG_RATE, REG_LEVEL, REG_HOLD};
		vals  = '{gain, rate, level, hold};
		cur_level = level;
		cur_hold  = hold;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VAL_W-1:0] pick_reg();
		case ($urandom_range(0, 3))
			0:       return 16'h0000;
			1:       return 16'hffff;
			2:       return VAL_W'($urandom_range(0, 4095));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_cell();
		case ($urandom_range(0, 7))
			0: return cur_hold;
			1: begin
				case ($urandom_range(0, 4))
					0:       return 16'sh7fff;
					1:       return 16'sh8000;
					2:       return 16'sh0000;
					3:       return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			2:       return VAL_W'(int'(cur_level) + int'($urandom_range(0, 128)) - 64);
			3, 4:    return VAL_W'(int'($urandom_range(0, 8192)) - 4096);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	initial begin
		int sent;
		int len;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_cell(16'sh7fff, 1'b1);
		send_cell(16'sh8000, 1'b1);
		send_cell(HOLD_RST, 1'b1);
		send_cell(16'sd0, 1'b0);
		send_cell(16'sd0, 1'b1);
		send_cell(16'sd4096, 1'b0);
		send_cell(HOLD_RST, 1'b0);
		send_cell(-16'sd4096, 1'b0);
		send_cell(-16'sd1, 1'b0);
		send_cell(16'sd1, 1'b1);
		drain();

		write_regs(16'hffff, 16'hffff, 16'h7fff, 16'h8000);
		send_cell(16'sh8000, 1'b0);
		send_cell(16'sh7fff, 1'b0);
		send_cell(16'sh8000, 1'b0);
		send_cell(16'sh7fff, 1'b1);
		send_cell(16'sh8000, 1'b1);
		drain();

		write_regs(16'h0000, 16'h0000, 16'h8000, 16'h7fff);
		send_cell(16'sh7fff, 1'b0);
		send_cell(16'sd12345, 1'b0);
		send_cell(16'sh8000, 1'b1);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0:       write_regs(16'hffff, 16'hffff, 16'h7fff, 16'h7fff);
				1:       write_regs(16'h0000, 16'h0000, 16'h8000, 16'h8000);
				2:       write_regs(GAIN_RST, RATE_RST, LEVEL_RST, HOLD_RST);
				default: write_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg());
			endcase
			sent = 0;
			while (sent < 180) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
					: $urandom_range(3, 24);
				row_burst = ($urandom_range(0, 3) == 0);
				for (int i = 0; i < len; i++)
					send_cell(pick_cell(), i == len - 1);
				sent += len;
			end
			drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
